### design/ssd_pkg.sv
// Package for the seven-segment shift driver: digit count, code tables, shared types.
// No dependencies; the front, queue, back and top level import it.
`default_nettype none

package ssd_pkg;

  // Number of digit positions shown, clamped into 1 .. 4
  localparam int DIGIT_COUNT = 4;
  localparam int NDIG = (DIGIT_COUNT < 1) ? 1 : ((DIGIT_COUNT > 4) ? 4 : DIGIT_COUNT);

  localparam int FRAME_BITS = 16;
  localparam int BIT_W      = 4;   // index of a bit within a frame
  localparam int POS_W      = 2;   // digit position, up to four positions

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NDIG - 1);
  localparam logic [BIT_W-1:0] TOP_BIT  = BIT_W'(FRAME_BITS - 1);

  // Reciprocal of ten: (x * 52429) >> 19 equals x / 10 for every 16-bit x
  localparam logic [31:0] RECIP_TEN = 32'd52429;
  localparam int          RECIP_SH  = 19;

  typedef logic [3:0] digit_t;
  typedef digit_t [NDIG-1:0] digit_set_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic not_empty;
    logic not_full;
  } qstat_t;

  // Active-low segment pattern of a decimal digit
  function automatic logic [7:0] seg_code(input digit_t d);
    logic [7:0] r;
    unique case (d)
      4'd0:    r = 8'd192;
      4'd1:    r = 8'd249;
      4'd2:    r = 8'd164;
      4'd3:    r = 8'd176;
      4'd4:    r = 8'd153;
      4'd5:    r = 8'd146;
      4'd6:    r = 8'd130;
      4'd7:    r = 8'd248;
      4'd8:    r = 8'd128;
      4'd9:    r = 8'd144;
      default: r = 8'd192;
    endcase
    return r;
  endfunction

  // One-hot position select
  function automatic logic [7:0] pos_code(input logic [POS_W-1:0] p);
    logic [7:0] r;
    unique case (p)
      2'd0:    r = 8'd1;
      2'd1:    r = 8'd2;
      2'd2:    r = 8'd4;
      default: r = 8'd8;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/ssd_if.sv
// Valid/ready channel interfaces for the value input and the serial bit output.
// Depends on nothing; used by the top level and its ports.
`default_nettype none

interface ssd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ssd_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch_pulse;
  logic last;

  modport source (output valid, output serial_bit, output latch_pulse, output last,
                  input ready);
  modport sink   (input valid, input serial_bit, input latch_pulse, input last,
                  output ready);
endinterface

`default_nettype wire

### design/ssd_front.sv
// Front part: accepts a value and splits it into decimal digits, one per cycle.
// Depends on ssd_pkg.
`default_nettype none

module ssd_front
  import ssd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_value,
  input  wire qstat_t      qstat,
  output logic             push,
  output digit_set_t       push_data
);

  logic             busy;
  logic             hold;
  logic [POS_W-1:0] cnt;
  logic [15:0]      v;
  digit_set_t       digs;

  logic [31:0] prod;
  logic [15:0] quot;
  digit_t      rem;

  // Divide by ten through the reciprocal, remainder by shift-and-add
  assign prod = 32'(v) * RECIP_TEN;
  assign quot = 16'(prod >> RECIP_SH);
  assign rem  = 4'(v - ((quot << 3) + (quot << 1)));

  assign in_ready  = !busy && !hold;
  assign push      = hold && qstat.not_full;
  assign push_data = digs;

  // Control: accept, one digit per cycle from the highest position down, then hand off
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      hold <= 1'b0;
      cnt  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        cnt  <= LAST_POS;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          hold <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      if (push) hold <= 1'b0;
    end
  end

  // Payload: working value and digit set
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      v <= in_value;
    end else if (busy) begin
      v         <= quot;
      digs[cnt] <= rem;
    end
  end

endmodule

`default_nettype wire

### design/ssd_queue.sv
// Two-entry queue of digit sets between the front and back parts.
// Depends on ssd_pkg.
`default_nettype none

module ssd_queue
  import ssd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire digit_set_t push_data,
  input  wire logic       pop,
  output digit_set_t      head,
  output qstat_t          qstat
);

  digit_set_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head            = mem[rd_ptr];
  assign qstat.not_empty = (count != 2'd0);
  assign qstat.not_full  = (count != 2'd2);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

### design/ssd_back.sv
// Back part: serializes each digit set into 16-bit frames, one bit per cycle unless the output stalls,
// through an output register. Depends on ssd_pkg.
`default_nettype none

module ssd_back
  import ssd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire qstat_t     qstat,
  input  wire digit_set_t head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_serial_bit,
  output logic            out_latch_pulse,
  output logic            out_last
);

  logic             active;
  logic [POS_W-1:0] pos;
  logic [BIT_W-1:0] bidx;
  digit_set_t       digs;

  logic        advance;
  logic        frame_end;
  logic        set_end;
  logic [15:0] frame;

  assign advance   = active && (!out_valid || out_ready);
  assign frame_end = (bidx == '0);
  assign set_end   = frame_end && (pos == LAST_POS);
  assign pop       = qstat.not_empty && (!active || (advance && set_end));
  assign frame     = {seg_code(digs[pos]), pos_code(pos)};

  // Sequencer over positions and frame bits
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
      bidx      <= TOP_BIT;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        active <= 1'b1;
        pos    <= '0;
        bidx   <= TOP_BIT;
      end else if (advance) begin
        if (frame_end) begin
          bidx <= TOP_BIT;
          if (set_end) begin
            active <= 1'b0;
          end else begin
            pos <= pos + 1'b1;
          end
        end else begin
          bidx <= bidx - 1'b1;
        end
      end
    end
  end

  // Payload: digit set and output bit
  always_ff @(posedge clk) begin
    if (pop) digs <= head;
    if (advance) begin
      out_serial_bit  <= frame[bidx];
      out_latch_pulse <= frame_end;
      out_last        <= set_end;
    end
  end

endmodule

`default_nettype wire

### design/seven_segment_shift_driver_unit.sv
// Seven-segment shift driver top level: front (digit split), queue, back (serializer).
// Throughput is set by the one-bit-per-cycle serializer, which stalls under output back-pressure;
// the front takes no new value until its digit set is pushed, and runs ahead by up to two queued values.
// Reset (rst, synchronous): empties the queue and output register, idles both parts.
// Depends on ssd_pkg, ssd_if, ssd_front, ssd_queue, ssd_back.
`default_nettype none

module seven_segment_shift_driver_unit
  import ssd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  ssd_in_if.sink      in_ch,
  ssd_out_if.source   out_ch
);

  qstat_t     qstat;
  logic       push;
  logic       pop;
  digit_set_t push_data;
  digit_set_t head;

  ssd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_value  (in_ch.value),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  ssd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  ssd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .qstat           (qstat),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_serial_bit  (out_ch.serial_bit),
    .out_latch_pulse (out_ch.latch_pulse),
    .out_last        (out_ch.last)
  );

endmodule

`default_nettype wire

### design/ssd_checker.sv
// Port-level checks for the seven-segment shift driver, bound to the top level.
// Depends on seven_segment_shift_driver_unit.
`default_nettype none

module ssd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic serial_bit,
  input wire logic latch_pulse,
  input wire logic last
);

  // A stalled bit holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({serial_bit, latch_pulse, last}))
    else $error("output item changed while stalled");

  // The final bit of a value always closes a frame
  a_last_latch: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> latch_pulse)
    else $error("last without latch pulse");

  // The front is busy right after taking a value
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accept");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind seven_segment_shift_driver_unit ssd_checker u_ssd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .serial_bit  (out_ch.serial_bit),
  .latch_pulse (out_ch.latch_pulse),
  .last        (out_ch.last)
);

`default_nettype wire
